// ===== sv/sjbf_pkg.sv =====
package sjbf_pkg;

    // Default FIFO size in bytes
    localparam int DEF_FIFO_DEPTH = 256;

    // Operation codes of an input word
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_SESSION = 2'd2;

    // Field widths
    localparam int PW_W   = 20;
    localparam int CD_W   = 24;
    localparam int CNT_W  = 32;
    localparam int SKIP_W = 4;
    localparam int FILL_W = 9;

    // Service timing: period = 8 * pulse width, fallback when the width is too short
    localparam int                PERIOD_SHIFT = 3;
    localparam logic [PW_W-1:0]   PW_MIN       = PW_W'(40);
    localparam logic [PW_W-1:0]   PW_FALLBACK  = PW_W'(12000);

    // Buffering thresholds
    localparam int                FILL_THRESH  = 8;
    localparam logic [SKIP_W-1:0] SKIP_LIMIT   = SKIP_W'(8);
    localparam logic [SKIP_W-1:0] SKIP_MAX     = SKIP_W'(15);

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic              deliver_valid;
        logic [7:0]        deliver_byte;
        logic              buffering_mode;
        logic [FILL_W-1:0] fill_level;
        logic [CNT_W-1:0]  lost_total;
        logic [CNT_W-1:0]  processed_total;
    } out_word_t;

endpackage

// ===== sv/sjbf_ram.sv =====
module sjbf_ram import sjbf_pkg::*;
#(
    parameter int DEPTH = DEF_FIFO_DEPTH,
    parameter int AW    = $clog2(DEF_FIFO_DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/serial_jitter_buffer_feeder.sv =====
// Serial jitter buffer feeder.
// Input channel (in_valid / in_stall / in_word): one word per event, either a
// received byte, a clock tick or a session start. Output channel (out_valid /
// out_stall / out_word): exactly one status word per input word, carrying the
// delivered byte (if a service event handed one to the UART), the buffering
// flag, the FIFO fill level and the lost / processed byte counters.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes the UART pulse
// width; cfg_ready is always high. Write it only while the block is idle.
// Pipeline: state update, FIFO RAM read and the pending stage load happen at
// the accepting edge; the output register loads from the pending stage once
// the output is free.
// Throughput: one word per cycle while the output is not stalled; the FIFO
// RAM read issued at acceptance is consumed when the pending stage advances,
// which bounds the pipeline to that single pending entry.
// Reset: FIFO empty, buffering mode on, counters and pulse width zero, the
// first tick is a service event. RAM contents are not cleared.
// Receiver stall: the output word holds, the pending stage fills, and then
// in_stall rises until the output register drains.
module serial_jitter_buffer_feeder import sjbf_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  in_word_t        in_word,
    output logic            out_valid,
    input  logic            out_stall,
    output out_word_t       out_word,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [PW_W-1:0] cfg_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int OW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
    localparam logic [OW-1:0] OCC_FULL = OW'(FIFO_DEPTH);
    localparam logic [OW-1:0] OCC_THR  = OW'(FILL_THRESH);

    // Architectural state
    logic [AW-1:0]     rd_ptr_reg,  rd_ptr_next;
    logic [AW-1:0]     wr_ptr_reg,  wr_ptr_next;
    logic [OW-1:0]     occ_reg,     occ_next;
    logic              buf_reg,     buf_next;
    logic [SKIP_W-1:0] skip_reg,    skip_next;
    logic [CD_W-1:0]   cd_reg,      cd_next;
    logic [CNT_W-1:0]  lost_reg,    lost_next;
    logic [CNT_W-1:0]  proc_reg,    proc_next;
    logic [PW_W-1:0]   pw_reg;

    // Pending stage and output register
    logic      pend_reg;
    logic      pend_dlv_reg;
    out_word_t pend_word_reg, pend_word_next;
    logic      out_valid_reg;
    out_word_t out_word_reg, out_word_next;

    logic            accept;
    logic            pend_adv;
    logic            push;
    logic            pop;
    logic [PW_W-1:0] pw_eff;
    logic [CD_W-1:0] cd_reload;
    logic [7:0]      rd_data;

    // Handshakes
    assign pend_adv  = pend_reg & (~out_valid_reg | ~out_stall);
    assign in_stall  = pend_reg & ~pend_adv;
    assign accept    = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Service period reload: 8 * effective pulse width - 1
    assign pw_eff    = (pw_reg < PW_MIN) ? PW_FALLBACK : pw_reg;
    assign cd_reload = CD_W'({pw_eff, {PERIOD_SHIFT{1'b0}}} - (PW_W + PERIOD_SHIFT)'(1));

    // Next state for one accepted word
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        occ_next    = occ_reg;
        buf_next    = buf_reg;
        skip_next   = skip_reg;
        cd_next     = cd_reg;
        lost_next   = lost_reg;
        proc_next   = proc_reg;
        push        = 1'b0;
        pop         = 1'b0;
        case (in_word.op)
            OP_BYTE:
            begin
                if (occ_reg < OCC_FULL)
                begin
                    push        = 1'b1;
                    wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + AW'(1);
                    occ_next    = occ_reg + OW'(1);
                    if (occ_next >= OCC_THR)
                    begin
                        buf_next = 1'b0;
                    end
                end
                else
                begin
                    lost_next = (&lost_reg) ? lost_reg : lost_reg + CNT_W'(1);
                end
            end
            OP_TICK:
            begin
                if (cd_reg != '0)
                begin
                    cd_next = cd_reg - CD_W'(1);
                end
                else
                begin
                    cd_next = cd_reload;
                    if (occ_reg == '0)
                    begin
                        buf_next = 1'b1;
                    end
                    else if (buf_reg)
                    begin
                        skip_next = (skip_reg == SKIP_MAX) ? skip_reg : skip_reg + SKIP_W'(1);
                        if (skip_next > SKIP_LIMIT)
                        begin
                            buf_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pop         = 1'b1;
                        rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + AW'(1);
                        occ_next    = occ_reg - OW'(1);
                        proc_next   = (&proc_reg) ? proc_reg : proc_reg + CNT_W'(1);
                        skip_next   = '0;
                    end
                end
            end
            OP_SESSION:
            begin
                lost_next = '0;
                proc_next = '0;
                skip_next = '0;
                cd_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Status word captured at acceptance; the byte joins it from the RAM
    always_comb
    begin
        pend_word_next                 = '0;
        pend_word_next.deliver_valid   = pop;
        pend_word_next.buffering_mode  = buf_next;
        pend_word_next.fill_level      = FILL_W'(occ_next);
        pend_word_next.lost_total      = lost_next;
        pend_word_next.processed_total = proc_next;
    end

    // FIFO storage
    sjbf_ram #(
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (accept & push),
        .waddr (wr_ptr_reg),
        .wdata (in_word.data_byte),
        .re    (accept & pop),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            occ_reg    <= '0;
            buf_reg    <= 1'b1;
            skip_reg   <= '0;
            cd_reg     <= '0;
            lost_reg   <= '0;
            proc_reg   <= '0;
        end
        else if (accept)
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            occ_reg    <= occ_next;
            buf_reg    <= buf_next;
            skip_reg   <= skip_next;
            cd_reg     <= cd_next;
            lost_reg   <= lost_next;
            proc_reg   <= proc_next;
        end
    end

    // Pulse width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pw_reg <= cfg_data;
        end
    end

    // Pending stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            pend_reg <= 1'b1;
        end
        else if (pend_adv)
        begin
            pend_reg <= 1'b0;
        end
    end

    // Pending stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_word_reg <= pend_word_next;
            pend_dlv_reg  <= pop;
        end
    end

    // Output word, byte forced to zero without a delivery
    always_comb
    begin
        out_word_next              = pend_word_reg;
        out_word_next.deliver_byte = pend_dlv_reg ? rd_data : 8'd0;
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pend_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (pend_adv)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

// ===== sv/sjbf_checker.sv =====
module sjbf_assertions import sjbf_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
)
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_stall,
    input in_word_t        in_word,
    input logic            out_valid,
    input logic            out_stall,
    input out_word_t       out_word
);

    localparam logic [FILL_W:0] MAX_FILL = (FIFO_DEPTH > 511) ? (FILL_W + 1)'(511)
                                                               : (FILL_W + 1)'(FIFO_DEPTH);

    // No byte without a delivery
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.deliver_valid |-> out_word.deliver_byte == 8'd0)
        else $error("deliver_byte set without delivery");

    // Delivery only happens outside buffering mode
    a_dlv_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.deliver_valid |-> !out_word.buffering_mode)
        else $error("delivery reported while buffering");

    // Fill level never exceeds the FIFO size
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {1'b0, out_word.fill_level} <= MAX_FILL)
        else $error("fill level beyond FIFO size");

    // Stalled result word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output word changed");

    // Stalled input word stays
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_word))
        else $error("stalled input word changed");

endmodule

bind serial_jitter_buffer_feeder sjbf_assertions #(.FIFO_DEPTH(FIFO_DEPTH)) u_sjbf_checker (.*);

// ===== sim/sjbf_checker.sv =====
`timescale 1ns / 100ps

// Watches the word, status and pulse width channels of the jitter buffer
// feeder, keeps its own copy of the buffer state and checks every status word.
module sjbf_checker import sjbf_pkg::*;
#(
    parameter int FIFO_DEPTH = DEF_FIFO_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  in_word_t        in_word,
    input  logic            out_valid,
    input  logic            out_stall,
    input  out_word_t       out_word,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [PW_W-1:0] cfg_data,
    output int              err_count,
    output int              pending
);

    localparam int MAX_PRINTED = 50;

    // Shadow of the buffer state
    logic [7:0]        byte_store [FIFO_DEPTH];
    int unsigned       head_idx;
    int unsigned       tail_idx;
    int unsigned       held_bytes;
    logic              buffering;
    logic [SKIP_W-1:0] skips;
    logic [CD_W-1:0]   countdown;
    logic [CNT_W-1:0]  lost_cnt;
    logic [CNT_W-1:0]  delivered_cnt;
    logic [PW_W-1:0]   pulse_width;

    // Status words still owed by the block, oldest first
    out_word_t status_q[$];
    out_word_t oldest;
    int        mismatches = 0;
    int        waiting = 0;

    assign err_count = mismatches;
    assign pending   = waiting;

    task automatic flag_mismatch(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (mismatches < MAX_PRINTED)
            $display("%0t sjbf_checker: %s expected %0h got %0h", $time, what, want, got);
        mismatches++;
    endtask

    function automatic logic [CNT_W-1:0] sat_incr(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Apply one word to the shadow state and return the status it yields
    function automatic out_word_t feed_word(in_word_t w);
        out_word_t       s;
        logic [PW_W-1:0] pw_eff;
        s = '0;
        case (w.op)
            OP_BYTE:
            begin
                if (held_bytes < FIFO_DEPTH)
                begin
                    byte_store[tail_idx] = w.data_byte;
                    tail_idx = (tail_idx + 1) % FIFO_DEPTH;
                    held_bytes++;
                    if (held_bytes >= FILL_THRESH)
                        buffering = 1'b0;
                end
                else
                begin
                    lost_cnt = sat_incr(lost_cnt);
                end
            end
            OP_TICK:
            begin
                if (countdown != '0)
                begin
                    countdown--;
                end
                else
                begin
                    // service event
                    if (held_bytes == 0)
                    begin
                        buffering = 1'b1;
                    end
                    else if (buffering)
                    begin
                        if (skips < SKIP_MAX)
                            skips++;
                        if (skips > SKIP_LIMIT)
                            buffering = 1'b0;
                    end
                    else
                    begin
                        s.deliver_valid = 1'b1;
                        s.deliver_byte  = byte_store[head_idx];
                        head_idx = (head_idx + 1) % FIFO_DEPTH;
                        held_bytes--;
                        delivered_cnt = sat_incr(delivered_cnt);
                        skips = '0;
                    end
                    // period is taken from the pulse width at this moment
                    pw_eff = (pulse_width < PW_MIN) ? PW_FALLBACK : pulse_width;
                    countdown = CD_W'((32'(pw_eff) << PERIOD_SHIFT) - 32'd1);
                end
            end
            OP_SESSION:
            begin
                lost_cnt      = '0;
                delivered_cnt = '0;
                skips         = '0;
                countdown     = '0;
            end
            default: ;
        endcase
        s.buffering_mode  = buffering;
        s.fill_level      = FILL_W'(held_bytes);
        s.lost_total      = lost_cnt;
        s.processed_total = delivered_cnt;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_idx      = 0;
            tail_idx      = 0;
            held_bytes    = 0;
            buffering     = 1'b1;
            skips         = '0;
            countdown     = '0;
            lost_cnt      = '0;
            delivered_cnt = '0;
            pulse_width   = '0;
            status_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                pulse_width = cfg_data;

            // compare a delivered status word with the oldest one owed
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    flag_mismatch("status word with none owed, fill_level", '0,
                        CNT_W'(out_word.fill_level));
                end
                else
                begin
                    oldest = status_q.pop_front();
                    if (out_word.deliver_valid !== oldest.deliver_valid)
                        flag_mismatch("deliver_valid", CNT_W'(oldest.deliver_valid),
                            CNT_W'(out_word.deliver_valid));
                    if (out_word.deliver_byte !== oldest.deliver_byte)
                        flag_mismatch("deliver_byte", CNT_W'(oldest.deliver_byte),
                            CNT_W'(out_word.deliver_byte));
                    if (out_word.buffering_mode !== oldest.buffering_mode)
                        flag_mismatch("buffering_mode", CNT_W'(oldest.buffering_mode),
                            CNT_W'(out_word.buffering_mode));
                    if (out_word.fill_level !== oldest.fill_level)
                        flag_mismatch("fill_level", CNT_W'(oldest.fill_level),
                            CNT_W'(out_word.fill_level));
                    if (out_word.lost_total !== oldest.lost_total)
                        flag_mismatch("lost_total", oldest.lost_total, out_word.lost_total);
                    if (out_word.processed_total !== oldest.processed_total)
                        flag_mismatch("processed_total", oldest.processed_total,
                            out_word.processed_total);
                end
            end

            if (in_valid && !in_stall)
                status_q.push_back(feed_word(in_word));
        end
        waiting = status_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import sjbf_pkg::*;

    // op value the block ignores
    localparam logic [1:0]      OP_UNUSED     = 2'd3;
    localparam int              WORDS_PER_SET = 175;
    localparam logic [PW_W-1:0] PW_FULL       = '1;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    in_word_t        in_word = '0;
    logic            out_valid;
    logic            out_stall = 1'b1;
    out_word_t       out_word;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [PW_W-1:0] cfg_data = '0;

    int              err_count;
    int              pending;
    int              tx_idle_pct = 0;
    int              rx_idle_pct = 0;
    int              words_sent = 0;
    logic [PW_W-1:0] pulse_setting = '0;

    always #10 clk = ~clk;

    serial_jitter_buffer_feeder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sjbf_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .err_count (err_count),
        .pending   (pending)
    );

    // Receiver: random stalls plus long hold-offs that back the block up
    initial
    begin
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (cyc == 400 || $urandom_range(0, 999) == 0)
            begin
                hold_left = $urandom_range(40, 80);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
            cyc++;
        end
    end

    // Offer one word, with random idle cycles ahead of it, until accepted
    task automatic send_word(logic [1:0] op, logic [7:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= {op, data};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op != OP_UNUSED)
            words_sent++;
    endtask

    // Session start then a tick: the tick is always a service event
    task automatic service_now();
        send_word(OP_SESSION, 8'($urandom));
        send_word(OP_TICK, 8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_pulse(logic [PW_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        pulse_setting = value;
    endtask

    // Random traffic: byte bursts, service bursts, floods, noise
    task automatic run_traffic(int quota);
        int start;
        int r;
        start  = words_sent;
        while (words_sent - start < quota)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                service_now();
                repeat ($urandom_range(0, 5))
                    send_word($urandom_range(0, 1) ? OP_BYTE : OP_TICK, 8'($urandom));
            end
            else if (r < 40)
            begin
                repeat ($urandom_range(1, 8))
                    send_word(OP_BYTE, 8'($urandom));
            end
            else if (r < 68)
            begin
                repeat ($urandom_range(1, 24))
                    service_now();
            end
            else if (r < 69)
            begin
                // overfill the FIFO
                repeat ($urandom_range(250, 300))
                    send_word(OP_BYTE, 8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_word(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 12;
        rx_idle_pct = 75;
        write_pulse(PW_FULL);

        // first tick after reset serves an empty FIFO, second only counts down
        send_word(OP_TICK, 8'h00);
        send_word(OP_TICK, 8'hFF);
        send_word(OP_UNUSED, 8'hFF);
        // four bytes: still buffering, then a skip
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'hA5);
        send_word(OP_BYTE, 8'h5A);
        service_now();
        // eighth byte ends buffering, then two deliveries
        send_word(OP_BYTE, 8'h01);
        send_word(OP_BYTE, 8'h02);
        send_word(OP_BYTE, 8'h03);
        send_word(OP_BYTE, 8'h04);
        service_now();
        service_now();
        send_word(OP_BYTE, 8'h80);
        send_word(OP_SESSION, 8'h00);

        write_pulse(PW_W'(40));
        // countdown runs out on its own: one full period of ticks after a service
        repeat (FILL_THRESH)
            send_word(OP_BYTE, 8'($urandom));
        service_now();
        repeat (int'(PW_MIN) << PERIOD_SHIFT)
            send_word(OP_TICK, 8'($urandom));
        run_traffic(WORDS_PER_SET);
        write_pulse(PW_FULL);
        run_traffic(WORDS_PER_SET);

        tx_idle_pct = 75;
        rx_idle_pct = 12;
        write_pulse(PW_W'(39));
        run_traffic(WORDS_PER_SET);
        write_pulse(PW_W'(41));
        run_traffic(WORDS_PER_SET);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_pulse('0);
        run_traffic(WORDS_PER_SET);
        write_pulse(PW_W'(40));
        run_traffic(WORDS_PER_SET);

        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100000000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sjbf_pkg.sv
sv/sjbf_ram.sv
sv/serial_jitter_buffer_feeder.sv
sv/sjbf_checker.sv
sim/sjbf_checker.sv
sim/tb_top.sv
